[design/vna_pkg.sv]
// Shared types and constants for the MIDI note voice allocator.
`default_nettype none

package vna_pkg;

   localparam int VNA_VOICE_COUNT = 8;
   localparam int VOICE_W         = 3;
   localparam int BYTE_W          = 8;

   localparam logic [BYTE_W-1:0] MSG_NOTE_ON  = 8'h90;
   localparam logic [BYTE_W-1:0] MSG_NOTE_OFF = 8'h80;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_STARTED  = 3'd1,
      EV_RELEASED = 3'd2,
      EV_NO_FREE  = 3'd3,
      EV_NO_MATCH = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_NOTE = 2'd1,
      PH_VEL  = 2'd2
   } phase_type;

   typedef struct packed {
      logic              start;
      logic              release_v;
      logic [BYTE_W-1:0] note;
   } pool_cmd_type;

   typedef struct packed {
      logic               free_hit;
      logic [VOICE_W-1:0] free_voice;
      logic               match_hit;
      logic [VOICE_W-1:0] match_voice;
   } pool_resp_type;

   typedef struct packed {
      event_type          event_res;
      logic [VOICE_W-1:0] voice;
      logic [BYTE_W-1:0]  note;
      logic [BYTE_W-1:0]  velocity;
   } rsp_type;

endpackage

`default_nettype wire

[design/midi_note_voice_allocator_top.sv]
// MIDI note on/off parser with voice allocation: top level.
//
// Takes one received MIDI byte per item and returns one result item per byte.
// A note on (0x90) or note off (0x80) status byte starts a message; the next
// two bytes are note and velocity. On the velocity byte a note on claims the
// lowest free voice and a note off frees the lowest active voice holding the
// same note; misses are reported with their own event code. Every byte is
// handled combinationally by the parser and the parallel voice search, and its
// result is registered in the output buffer; one item is accepted per clock
// while that buffer has room. A two-entry output buffer keeps req_ready high
// while one result waits; input stalls only when both entries are full.
`default_nettype none

module midi_note_voice_allocator_top
   import vna_pkg::*;
#(
   parameter int VOICE_COUNT = VNA_VOICE_COUNT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic [BYTE_W-1:0]   req_rx_byte,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic [2:0]          rsp_event_res,
   output      logic [VOICE_W-1:0]  rsp_voice,
   output      logic [BYTE_W-1:0]   rsp_note,
   output      logic [BYTE_W-1:0]   rsp_velocity
);

   phase_type          phase_ff, phase_in;
   logic               pending_on_ff, pending_on_in;
   logic               pending_off_ff, pending_off_in;
   logic [BYTE_W-1:0]  held_note_ff, held_note_in;

   logic               main_valid_ff, main_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   rsp_type            main_ff, main_in;
   rsp_type            skid_ff, skid_in;

   logic               push, pop;
   rsp_type            result;
   pool_cmd_type       pool_cmd;
   pool_resp_type      pool_resp;

   assign req_ready = !skid_valid_ff;
   assign push      = req_valid && req_ready;
   assign pop       = main_valid_ff && rsp_ready;

   vna_voice_pool #(
      .VOICE_COUNT(VOICE_COUNT)
   ) u_pool (
      .clock(clock),
      .reset(reset),
      .cmd  (pool_cmd),
      .resp (pool_resp)
   );

   // next state of the parser
   always_comb begin
      phase_in       = phase_ff;
      pending_on_in  = pending_on_ff;
      pending_off_in = pending_off_ff;
      held_note_in   = held_note_ff;
      if (push) begin
         unique case (phase_ff)
            PH_NOTE: begin
               held_note_in = req_rx_byte;
               phase_in     = PH_VEL;
            end
            PH_VEL: begin
               phase_in       = PH_IDLE;
               pending_on_in  = 1'b0;
               pending_off_in = 1'b0;
            end
            default: begin
               phase_in = PH_IDLE;
               if (req_rx_byte == MSG_NOTE_ON) begin
                  pending_on_in = 1'b1;
                  phase_in      = PH_NOTE;
               end else if (req_rx_byte == MSG_NOTE_OFF) begin
                  pending_off_in = 1'b1;
                  phase_in       = PH_NOTE;
               end
            end
         endcase
      end
   end

   // outputs of the parser: pool command and result item
   always_comb begin
      pool_cmd.start     = 1'b0;
      pool_cmd.release_v = 1'b0;
      pool_cmd.note      = held_note_ff;
      result.event_res   = EV_NONE;
      result.voice       = '0;
      result.note        = '0;
      result.velocity    = '0;
      if (phase_ff == PH_VEL) begin
         if (pending_on_ff) begin
            pool_cmd.start   = push;
            result.note      = held_note_ff;
            result.velocity  = req_rx_byte;
            result.event_res = pool_resp.free_hit ? EV_STARTED : EV_NO_FREE;
            result.voice     = pool_resp.free_hit ? pool_resp.free_voice : '0;
         end else if (pending_off_ff) begin
            pool_cmd.release_v = push;
            result.note        = held_note_ff;
            result.velocity    = req_rx_byte;
            result.event_res   = pool_resp.match_hit ? EV_RELEASED : EV_NO_MATCH;
            result.voice       = pool_resp.match_hit ? pool_resp.match_voice : '0;
         end
      end
   end

   // two-entry result buffer
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = result;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         pending_on_ff  <= 1'b0;
         pending_off_ff <= 1'b0;
         held_note_ff   <= '0;
         main_valid_ff  <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         pending_on_ff  <= pending_on_in;
         pending_off_ff <= pending_off_in;
         held_note_ff   <= held_note_in;
         main_valid_ff  <= main_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = main_valid_ff;
   assign rsp_event_res = main_ff.event_res;
   assign rsp_voice     = main_ff.voice;
   assign rsp_note      = main_ff.note;
   assign rsp_velocity  = main_ff.velocity;

`ifndef NO_ASSERTIONS
   a_skid_implies_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held while main entry empty");

   a_single_kind: assert property (@(posedge clock) disable iff (reset)
      !(pending_on_ff && pending_off_ff))
      else $error("note on and note off pending together");

   a_kind_in_message: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (pending_on_ff || pending_off_ff))
      else $error("message in progress without a kind");

   a_vel_ends_message: assert property (@(posedge clock) disable iff (reset)
      push && (phase_ff == PH_VEL) |=> (phase_ff == PH_IDLE))
      else $error("velocity byte did not end the message");
`endif

endmodule

`default_nettype wire

[design/vna_voice_pool.sv]
// Voice table: active flags, stored notes and lowest-index free/match search.
`default_nettype none

module vna_voice_pool
   import vna_pkg::*;
#(
   parameter int VOICE_COUNT = VNA_VOICE_COUNT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire pool_cmd_type  cmd,
   output pool_resp_type      resp
);

   logic [VOICE_COUNT-1:0] active_ff, active_in;
   logic [BYTE_W-1:0]      note_ff [VOICE_COUNT];
   logic [VOICE_COUNT-1:0] free_vec, match_vec, free_sel, match_sel;

   always_comb begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
         match_vec[i] = active_ff[i] && (note_ff[i] == cmd.note);
      end
      free_vec  = ~active_ff;
      free_sel  = free_vec & (~free_vec + 1'b1);
      match_sel = match_vec & (~match_vec + 1'b1);
   end

   always_comb begin
      resp.free_hit    = |free_vec;
      resp.match_hit   = |match_vec;
      resp.free_voice  = '0;
      resp.match_voice = '0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
         if (free_sel[i]) begin
            resp.free_voice = resp.free_voice | VOICE_W'(i);
         end
         if (match_sel[i]) begin
            resp.match_voice = resp.match_voice | VOICE_W'(i);
         end
      end
   end

   always_comb begin
      active_in = active_ff;
      if (cmd.start) begin
         active_in = active_ff | free_sel;
      end else if (cmd.release_v) begin
         active_in = active_ff & ~match_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
         if (cmd.start && free_sel[i]) begin
            note_ff[i] <= cmd.note;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_start_claims_one: assert property (@(posedge clock) disable iff (reset)
      cmd.start && resp.free_hit |=>
         $countones(active_ff) == $past($countones(active_ff)) + 1)
      else $error("start did not claim exactly one voice");

   a_release_frees_one: assert property (@(posedge clock) disable iff (reset)
      cmd.release_v && resp.match_hit |=>
         $countones(active_ff) + 1 == $past($countones(active_ff)))
      else $error("release did not free exactly one voice");

   a_no_start_and_release: assert property (@(posedge clock) disable iff (reset)
      !(cmd.start && cmd.release_v))
      else $error("start and release in the same cycle");
`endif

endmodule

`default_nettype wire

[dv/midi_note_voice_allocator_top_test.sv]
// Self-checking testbench for the MIDI note voice allocator: directed and random byte streams.

module midi_note_voice_allocator_top_test
   import vna_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1250;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 10;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_rx_byte = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   logic [2:0]          rsp_event_res;
   logic [VOICE_W-1:0]  rsp_voice;
   logic [BYTE_W-1:0]   rsp_note;
   logic [BYTE_W-1:0]   rsp_velocity;

   // parser and voice pool as predicted
   phase_type          msg_phase;
   logic               msg_is_on;
   logic               msg_is_off;
   logic [BYTE_W-1:0]  msg_note;
   logic               voice_busy  [VNA_VOICE_COUNT];
   logic [BYTE_W-1:0]  voice_pitch [VNA_VOICE_COUNT];

   rsp_type  pending_events[$];
   int       err_count   = 0;
   int       idle_cycles = 0;
   int       burst_left  = 0;
   int       stall_left  = 0;
   int       stall_mode  = 0;
   int       stall_tick  = 0;

   midi_note_voice_allocator_top #(
      .VOICE_COUNT(VNA_VOICE_COUNT)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_event_res(rsp_event_res),
      .rsp_voice    (rsp_voice),
      .rsp_note     (rsp_note),
      .rsp_velocity (rsp_velocity)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      err_count++;
   endtask

   function automatic void clear_voice_pool();
      msg_phase  = PH_IDLE;
      msg_is_on  = 1'b0;
      msg_is_off = 1'b0;
      msg_note   = '0;
      for (int i = 0; i < VNA_VOICE_COUNT; i++) begin
         voice_busy[i]  = 1'b0;
         voice_pitch[i] = '0;
      end
   endfunction

   function automatic rsp_type predict_voice_event(input logic [BYTE_W-1:0] b);
      rsp_type r;
      logic    done;
      r    = '0;
      done = 1'b0;
      case (msg_phase)
         PH_NOTE: begin
            msg_note  = b;
            msg_phase = PH_VEL;
         end
         PH_VEL: begin
            msg_phase = PH_IDLE;
            if (msg_is_on) begin
               for (int i = 0; i < VNA_VOICE_COUNT; i++) begin
                  if (!done && !voice_busy[i]) begin
                     voice_busy[i]  = 1'b1;
                     voice_pitch[i] = msg_note;
                     r.event_res    = EV_STARTED;
                     r.voice        = VOICE_W'(i);
                     done           = 1'b1;
                  end
               end
               if (!done) r.event_res = EV_NO_FREE;
               r.note     = msg_note;
               r.velocity = b;
            end else if (msg_is_off) begin
               for (int i = 0; i < VNA_VOICE_COUNT; i++) begin
                  if (!done && voice_busy[i] && voice_pitch[i] == msg_note) begin
                     voice_busy[i] = 1'b0;
                     r.event_res   = EV_RELEASED;
                     r.voice       = VOICE_W'(i);
                     done          = 1'b1;
                  end
               end
               if (!done) r.event_res = EV_NO_MATCH;
               r.note     = msg_note;
               r.velocity = b;
            end
            msg_is_on  = 1'b0;
            msg_is_off = 1'b0;
         end
         default: begin
            msg_phase = PH_IDLE;
            if (b == MSG_NOTE_ON) begin
               msg_is_on = 1'b1;
               msg_phase = PH_NOTE;
            end else if (b == MSG_NOTE_OFF) begin
               msg_is_off = 1'b1;
               msg_phase  = PH_NOTE;
            end
         end
      endcase
      return r;
   endfunction

   // predict on each accepted byte, then check each accepted result
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_voice_pool();
         pending_events.delete();
         idle_cycles = 0;
      end else begin
         if (req_valid && req_ready)
            pending_events.push_back(predict_voice_event(req_rx_byte));
         if (rsp_valid && rsp_ready) begin
            if (pending_events.size() == 0) begin
               report_mismatch($sformatf("unexpected result item ev=%0d voice=%0d",
                                         rsp_event_res, rsp_voice));
            end else begin
               want = pending_events.pop_front();
               if (rsp_event_res !== want.event_res)
                  report_mismatch($sformatf("event_res %0d, expected %s",
                                            rsp_event_res, want.event_res.name()));
               if (rsp_voice !== want.voice)
                  report_mismatch($sformatf("voice %0d, expected %0d", rsp_voice, want.voice));
               if (rsp_note !== want.note)
                  report_mismatch($sformatf("note %h, expected %h", rsp_note, want.note));
               if (rsp_velocity !== want.velocity)
                  report_mismatch($sformatf("velocity %h, expected %h",
                                            rsp_velocity, want.velocity));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // receiver back-pressure, switching between patterns at random
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 1) == 1);
         2:       rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ((stall_tick % 8) < 3);
      endcase
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 40);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_message(input logic [BYTE_W-1:0] status,
                               input logic [BYTE_W-1:0] note,
                               input logic [BYTE_W-1:0] velocity);
      send_byte(status);
      send_byte(note);
      send_byte(velocity);
   endtask

   // bytes other than a note on or note off status in idle produce empty results
   task automatic test_ignored_bytes();
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(8'hFF);
      send_byte(8'h81);
   endtask

   // claim, release, miss on release, reclaim of a freed voice
   task automatic test_note_on_off();
      send_message(MSG_NOTE_ON,  8'h00, 8'hFF);
      send_message(MSG_NOTE_ON,  8'h90, 8'h80);
      send_message(MSG_NOTE_OFF, 8'h00, 8'h7F);
      send_message(MSG_NOTE_OFF, 8'h00, 8'h01);
      send_message(MSG_NOTE_ON,  8'hFF, 8'h00);
   endtask

   // same note on two voices: release takes the lower one
   task automatic test_duplicate_notes();
      send_message(MSG_NOTE_ON,  8'h90, 8'h40);
      send_message(MSG_NOTE_OFF, 8'h90, 8'hC0);
   endtask

   task automatic test_random_traffic();
      int                 sent;
      int                 epoch;
      int                 on_pct;
      logic [BYTE_W-1:0]  status;
      logic [BYTE_W-1:0]  note;
      sent   = 0;
      epoch  = 0;
      on_pct = 50;
      while (sent < RANDOM_ITEMS) begin
         if (epoch == 0) begin
            epoch = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
               0:       on_pct = 15;
               1:       on_pct = 50;
               default: on_pct = 90;
            endcase
         end
         epoch--;
         status = ($urandom_range(0, 99) < on_pct) ? MSG_NOTE_ON : MSG_NOTE_OFF;
         note   = ($urandom_range(0, 6) == 0) ? BYTE_W'($urandom_range(0, 255))
                                               : BYTE_W'(8'h3C + $urandom_range(0, 11));
         case ($urandom_range(0, 19))
            0, 1: begin
               send_byte(BYTE_W'($urandom_range(0, 255)));
               sent += 1;
            end
            2: begin
               // truncated message: the next byte sent lands in the velocity slot
               send_byte(status);
               send_byte(note);
               sent += 2;
            end
            default: begin
               send_message(status, note, BYTE_W'($urandom_range(0, 255)));
               sent += 3;
            end
         endcase
      end
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_events.size() != 0)
         report_mismatch($sformatf("%0d result items never arrived", pending_events.size()));
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_ignored_bytes();
      test_note_on_off();
      test_duplicate_notes();
      test_random_traffic();
      finish_run();
      if (err_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
